### sv/rpu_pkg.sv
// rpu_pkg: shared types, constants and the character classifier of the
// roman numeral parser. No dependencies; every file but rpu_if uses it.
package rpu_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // character codes of the numeral letters
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_M = 8'h4D;

    // digit groups in grammar order
    localparam logic [1:0] GRP_THOUSANDS = 2'd0;
    localparam logic [1:0] GRP_HUNDREDS  = 2'd1;
    localparam logic [1:0] GRP_TENS      = 2'd2;
    localparam logic [1:0] GRP_UNITS     = 2'd3;

    // place inside a hundreds, tens or units group
    localparam logic [1:0] SUB_START  = 2'd0;
    localparam logic [1:0] SUB_ONE    = 2'd1;
    localparam logic [1:0] SUB_REPEAT = 2'd2;
    localparam logic [1:0] SUB_CLOSED = 2'd3;

    typedef enum logic [2:0] {
        SYM_I, SYM_V, SYM_X, SYM_L, SYM_C, SYM_D, SYM_M, SYM_NONE
    } t_sym;

    // one classified request travelling from front to back
    typedef struct packed {
        t_sym       sym;
        logic [7:0] ch;
        logic       is_end;
    } t_item;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // map a byte to its numeral letter
    function automatic t_sym classify(input logic [7:0] ch);
        t_sym s;
        case (ch)
            CH_I:    s = SYM_I;
            CH_V:    s = SYM_V;
            CH_X:    s = SYM_X;
            CH_L:    s = SYM_L;
            CH_C:    s = SYM_C;
            CH_D:    s = SYM_D;
            CH_M:    s = SYM_M;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage

### sv/rpu_if.sv
// rpu_in_if and rpu_out_if: valid/ready channels of the numeral parser.
// Depends on nothing but the field widths of the block.
interface rpu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface rpu_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] value;
    logic        ok;
    logic [7:0]  bad_char;

    modport source (output valid, output value, output ok, output bad_char, input ready);
    modport sink   (input valid, input value, input ok, input bad_char, output ready);
endinterface

### sv/roman_numeral_parser_unit.sv
// roman_numeral_parser_unit: top level of the roman numeral parser.
// Depends on rpu_pkg, rpu_if, rpu_front, rpu_queue and rpu_back.
//
// Usage: characters of a numeral arrive on i_in one request each (ch, with
// is_end low), followed by one request with is_end high. Letters produce no
// output; the end marker produces one result on o_out: value (0..3999) of the
// greedily parsed prefix, ok high when every character was taken, and
// bad_char, the first character that was not taken (0 when ok).
// Both channels use valid/ready; a request moves when both are high.
// Throughput: one request per cycle on both channels while o_out is ready.
// The result of an end marker is registered: it is written into the queue
// when accepted, then popped through the grammar update into the result
// register once that register is free.
// Reset (synchronous, active low) empties the queue, drops any pending result
// and puts the grammar at the start of the thousands group.
// When o_out stalls, the result register holds; letters of the next numeral
// keep being parsed, and only a second end marker waits at the queue head.
// Once the queue of QUEUE_DEPTH requests is full, i_in.ready goes low.
module roman_numeral_parser_unit #(
    parameter int QUEUE_DEPTH = rpu_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpu_in_if.sink     i_in,
    rpu_out_if.source  o_out
);

    rpu_pkg::t_q_status q_status;
    rpu_pkg::t_item     push_item;
    rpu_pkg::t_item     head_item;
    logic               push;
    logic               pop;
    logic               head_valid;

    rpu_front u_front (
        .i_in     (i_in),
        .i_status (q_status),
        .o_push   (push),
        .o_item   (push_item)
    );

    rpu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_status    (q_status),
        .i_pop       (pop),
        .o_valid     (head_valid),
        .o_head      (head_item)
    );

    rpu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_head  (head_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### sv/rpu_queue.sv
// rpu_queue: small register queue of classified requests between front and back.
// Depends on rpu_pkg for the item and status types.
module rpu_queue #(
    parameter int DEPTH = rpu_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rpu_pkg::t_item      i_push_item,
    output rpu_pkg::t_q_status  o_status,
    input  logic                i_pop,
    output logic                o_valid,
    output rpu_pkg::t_item      o_head
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rpu_pkg::t_item r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_valid        = (r_cnt != '0);
    assign o_head         = r_mem[r_rd];

    // fill count never passes the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    // a full queue is not pushed without a pop
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(DEPTH)) && i_push |-> i_pop)
        else $error("push into full queue");

    // read and write pointers are equal while the queue is empty
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");

endmodule

### sv/rpu_front.sv
// rpu_front: accepts character requests and classifies them into numeral letters.
// Depends on rpu_pkg and rpu_in_if; feeds rpu_queue.
module rpu_front (
    rpu_in_if.sink              i_in,
    input  rpu_pkg::t_q_status  i_status,
    output logic                o_push,
    output rpu_pkg::t_item      o_item
);

    // take a request whenever the queue has room
    assign i_in.ready = !i_status.full;
    assign o_push     = i_in.valid && !i_status.full;

    // classify the byte; end markers carry no letter
    always_comb begin
        o_item.ch     = i_in.ch;
        o_item.is_end = i_in.is_end;
        o_item.sym    = i_in.is_end ? rpu_pkg::SYM_NONE : rpu_pkg::classify(i_in.ch);
    end

endmodule

### sv/rpu_back.sv
// rpu_back: grammar state of the numeral and the registered result stage.
// Depends on rpu_pkg and rpu_out_if; drains rpu_queue.
module rpu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rpu_pkg::t_item  i_head,
    output logic            o_pop,
    rpu_out_if.source       o_out
);

    typedef struct packed {
        logic       hit;
        logic [3:0] dig;
        logic [1:0] sub;
    } t_take;

    // one letter into a hundreds, tens or units group
    function automatic t_take group_take(
        input rpu_pkg::t_sym sym,
        input rpu_pkg::t_sym one,
        input rpu_pkg::t_sym five,
        input rpu_pkg::t_sym ten,
        input logic [1:0]    sub,
        input logic [3:0]    dig
    );
        t_take t;
        t.hit = 1'b0;
        t.dig = dig;
        t.sub = sub;
        case (sub)
            rpu_pkg::SUB_START: begin
                if (sym == one) begin
                    t = '{1'b1, 4'd1, rpu_pkg::SUB_ONE};
                end else if (sym == five) begin
                    t = '{1'b1, 4'd5, rpu_pkg::SUB_REPEAT};
                end
            end
            rpu_pkg::SUB_ONE: begin
                if (sym == ten) begin
                    t = '{1'b1, 4'd9, rpu_pkg::SUB_CLOSED};
                end else if (sym == five) begin
                    t = '{1'b1, 4'd4, rpu_pkg::SUB_CLOSED};
                end else if (sym == one) begin
                    t = '{1'b1, 4'd2, rpu_pkg::SUB_REPEAT};
                end
            end
            default: begin
                // repeats allowed while the digit mod five is below three
                if (sym == one && (dig < 4'd3 || (dig >= 4'd5 && dig < 4'd8))) begin
                    t.hit = 1'b1;
                    t.dig = dig + 4'd1;
                end
            end
        endcase
        return t;
    endfunction

    logic [1:0] r_grp, n_grp;
    logic [1:0] r_sub, n_sub;
    logic [1:0] r_thou, n_thou;
    logic [3:0] r_hund, n_hund;
    logic [3:0] r_tens, n_tens;
    logic [3:0] r_units, n_units;
    logic       r_failed, n_failed;
    logic [7:0] r_bad, n_bad;

    logic        r_out_valid;
    logic [11:0] r_value;
    logic        r_ok;
    logic [7:0]  r_bad_char;

    logic        hit_thou;
    t_take       tk_hund, tk_tens, tk_units;
    logic        emit;
    logic [11:0] value;

    // end markers wait for a free result register, letters never do
    assign o_pop = i_valid && (!i_head.is_end || !r_out_valid || o_out.ready);
    assign emit  = o_pop && i_head.is_end;

    // each group tried from its start unless it is the current group
    always_comb begin
        hit_thou = (r_grp == rpu_pkg::GRP_THOUSANDS) && (i_head.sym == rpu_pkg::SYM_M)
                   && (r_thou < 2'd3);
        tk_hund  = group_take(i_head.sym, rpu_pkg::SYM_C, rpu_pkg::SYM_D, rpu_pkg::SYM_M,
                       (r_grp == rpu_pkg::GRP_HUNDREDS) ? r_sub : rpu_pkg::SUB_START,
                       r_hund);
        tk_tens  = group_take(i_head.sym, rpu_pkg::SYM_X, rpu_pkg::SYM_L, rpu_pkg::SYM_C,
                       (r_grp == rpu_pkg::GRP_TENS) ? r_sub : rpu_pkg::SUB_START,
                       r_tens);
        tk_units = group_take(i_head.sym, rpu_pkg::SYM_I, rpu_pkg::SYM_V, rpu_pkg::SYM_X,
                       (r_grp == rpu_pkg::GRP_UNITS) ? r_sub : rpu_pkg::SUB_START,
                       r_units);
    end

    // decimal value of the digits held
    assign value = 12'(r_thou) * 12'd1000 + 12'(r_hund) * 12'd100
                 + 12'(r_tens) * 12'd10 + 12'(r_units);

    // grammar state update
    always_comb begin
        n_grp    = r_grp;
        n_sub    = r_sub;
        n_thou   = r_thou;
        n_hund   = r_hund;
        n_tens   = r_tens;
        n_units  = r_units;
        n_failed = r_failed;
        n_bad    = r_bad;
        if (emit) begin
            n_grp    = rpu_pkg::GRP_THOUSANDS;
            n_sub    = rpu_pkg::SUB_START;
            n_thou   = '0;
            n_hund   = '0;
            n_tens   = '0;
            n_units  = '0;
            n_failed = 1'b0;
            n_bad    = '0;
        end else if (o_pop && !r_failed) begin
            if (hit_thou) begin
                n_thou = r_thou + 2'd1;
            end else if (r_grp <= rpu_pkg::GRP_HUNDREDS && tk_hund.hit) begin
                n_grp  = rpu_pkg::GRP_HUNDREDS;
                n_sub  = tk_hund.sub;
                n_hund = tk_hund.dig;
            end else if (r_grp <= rpu_pkg::GRP_TENS && tk_tens.hit) begin
                n_grp  = rpu_pkg::GRP_TENS;
                n_sub  = tk_tens.sub;
                n_tens = tk_tens.dig;
            end else if (tk_units.hit) begin
                n_grp   = rpu_pkg::GRP_UNITS;
                n_sub   = tk_units.sub;
                n_units = tk_units.dig;
            end else begin
                n_failed = 1'b1;
                n_bad    = i_head.ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp    <= rpu_pkg::GRP_THOUSANDS;
            r_sub    <= rpu_pkg::SUB_START;
            r_thou   <= '0;
            r_hund   <= '0;
            r_tens   <= '0;
            r_units  <= '0;
            r_failed <= 1'b0;
            r_bad    <= '0;
        end else begin
            r_grp    <= n_grp;
            r_sub    <= n_sub;
            r_thou   <= n_thou;
            r_hund   <= n_hund;
            r_tens   <= n_tens;
            r_units  <= n_units;
            r_failed <= n_failed;
            r_bad    <= n_bad;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value    <= value;
            r_ok       <= !r_failed;
            r_bad_char <= r_failed ? r_bad : 8'd0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.value    = r_value;
    assign o_out.ok       = r_ok;
    assign o_out.bad_char = r_bad_char;

    // an end marker returns the grammar to its start
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_grp == rpu_pkg::GRP_THOUSANDS) && !r_failed && (r_thou == 2'd0)
                 && (r_hund == 4'd0) && (r_tens == 4'd0) && (r_units == 4'd0))
        else $error("state not cleared after end marker");

    // digits stay decimal
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hund <= 4'd9) && (r_tens <= 4'd9) && (r_units <= 4'd9))
        else $error("digit out of range");

    // a clean result reports no bad character
    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ok |-> (r_bad_char == 8'd0))
        else $error("bad character on a clean result");

    // value never passes the largest numeral
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_value <= 12'd3999))
        else $error("value out of range");

endmodule

### test/roman_numeral_parser_unit_tb.sv
// roman_numeral_parser_unit_tb: self-checking testbench of the roman numeral parser.
// Depends on rpu_pkg, rpu_if and roman_numeral_parser_unit; checks every result
// against a grammar predictor kept in step with each accepted request.
module roman_numeral_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int RANDOM_TARGET   = 420;
    localparam int TOTAL_TARGET    = 760;

    typedef logic [7:0] t_char_q [$];

    typedef struct packed {
        logic [11:0] value;
        logic        ok;
        logic [7:0]  bad_char;
    } t_numeral_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rpu_in_if  in_ch ();
    rpu_out_if out_ch ();

    roman_numeral_parser_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state: group, place inside it and the digits found so far
    logic [1:0] grp;
    logic [1:0] sub;
    logic       past_units;
    logic [3:0] digits [4];
    logic       seen_bad;
    logic [7:0] first_bad_ch;

    t_numeral_result pending_results [$];
    int  requests_sent  = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;
    bit  hold_request   = 1'b0;

    // clock
    always #6 i_clk = ~i_clk;

    // back to the start of the thousands group
    task automatic clear_parse();
        grp          = rpu_pkg::GRP_THOUSANDS;
        sub          = rpu_pkg::SUB_START;
        past_units   = 1'b0;
        digits       = '{default: 4'd0};
        seen_bad     = 1'b0;
        first_bad_ch = 8'd0;
    endtask

    // greedy strict grammar step for one character
    task automatic parse_char(input logic [7:0] c);
        logic [7:0] one;
        logic [7:0] five;
        logic [7:0] ten;
        bit         taken;
        taken = 1'b0;
        if (seen_bad)
            return;
        while (!taken && !past_units) begin
            case (grp)
                rpu_pkg::GRP_HUNDREDS: begin
                    one = rpu_pkg::CH_C; five = rpu_pkg::CH_D; ten = rpu_pkg::CH_M;
                end
                rpu_pkg::GRP_TENS: begin
                    one = rpu_pkg::CH_X; five = rpu_pkg::CH_L; ten = rpu_pkg::CH_C;
                end
                default: begin
                    one = rpu_pkg::CH_I; five = rpu_pkg::CH_V; ten = rpu_pkg::CH_X;
                end
            endcase
            if (grp == rpu_pkg::GRP_THOUSANDS) begin
                if (c == rpu_pkg::CH_M && digits[rpu_pkg::GRP_THOUSANDS] < 4'd3) begin
                    digits[rpu_pkg::GRP_THOUSANDS] += 4'd1;
                    taken = 1'b1;
                end
            end else if (sub == rpu_pkg::SUB_START) begin
                if (c == one) begin
                    digits[grp] = 4'd1;
                    sub         = rpu_pkg::SUB_ONE;
                    taken       = 1'b1;
                end else if (c == five) begin
                    digits[grp] = 4'd5;
                    sub         = rpu_pkg::SUB_REPEAT;
                    taken       = 1'b1;
                end
            end else if (sub == rpu_pkg::SUB_ONE) begin
                if (c == ten) begin
                    digits[grp] = 4'd9;
                    sub         = rpu_pkg::SUB_CLOSED;
                    taken       = 1'b1;
                end else if (c == five) begin
                    digits[grp] = 4'd4;
                    sub         = rpu_pkg::SUB_CLOSED;
                    taken       = 1'b1;
                end else if (c == one) begin
                    digits[grp] = 4'd2;
                    sub         = rpu_pkg::SUB_REPEAT;
                    taken       = 1'b1;
                end
            end else if (c == one && digits[grp] % 5 < 3) begin
                // third repetition still counts, a fourth does not
                digits[grp] += 4'd1;
                taken = 1'b1;
            end
            // this group cannot take it, try the next one
            if (!taken) begin
                if (grp == rpu_pkg::GRP_UNITS) begin
                    past_units = 1'b1;
                end else begin
                    grp = grp + 2'd1;
                    sub = rpu_pkg::SUB_START;
                end
            end
        end
        if (!taken) begin
            seen_bad     = 1'b1;
            first_bad_ch = c;
        end
    endtask

    // end marker: queue the value of the parsed prefix and start afresh
    task automatic finish_numeral();
        t_numeral_result r;
        int              v;
        v = ((int'(digits[rpu_pkg::GRP_THOUSANDS]) * 10
              + int'(digits[rpu_pkg::GRP_HUNDREDS])) * 10
             + int'(digits[rpu_pkg::GRP_TENS])) * 10 + int'(digits[rpu_pkg::GRP_UNITS]);
        r.value    = 12'(v);
        r.ok       = !seen_bad;
        r.bad_char = seen_bad ? first_bad_ch : 8'd0;
        pending_results.push_back(r);
        clear_parse();
    endtask

    // one request on the input channel, predicted once it is accepted
    task automatic send_request(input logic [7:0] c, input logic e);
        while (sender_idles && $urandom_range(99) < 25) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.ch     <= c;
        in_ch.is_end <= e;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        requests_sent++;
        if (e)
            finish_numeral();
        else
            parse_char(c);
    endtask

    // characters of one numeral, then the end marker with a random byte
    task automatic send_numeral(input t_char_q chars);
        foreach (chars[i])
            send_request(chars[i], 1'b0);
        send_request(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        t_char_q chars;
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
        send_numeral(chars);
    endtask

    // letters of one decimal digit with the given one, five and ten letters
    function automatic void add_digit(inout t_char_q chars, input int d,
                                      input logic [7:0] one, five, ten);
        if (d == 9) begin
            chars.push_back(one);
            chars.push_back(ten);
        end else if (d == 4) begin
            chars.push_back(one);
            chars.push_back(five);
        end else begin
            if (d >= 5)
                chars.push_back(five);
            repeat (d % 5) chars.push_back(one);
        end
    endfunction

    // mostly well-formed numerals, some with a stray letter or byte, some pure noise
    function automatic t_char_q random_numeral();
        t_char_q    chars;
        logic [7:0] letters [7] = '{rpu_pkg::CH_I, rpu_pkg::CH_V, rpu_pkg::CH_X,
                                    rpu_pkg::CH_L, rpu_pkg::CH_C, rpu_pkg::CH_D,
                                    rpu_pkg::CH_M};
        int         pick;
        int         pos;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(4)) chars.push_back(8'($urandom_range(255)));
        end else if (pick < 15) begin
            repeat ($urandom_range(1, 6)) chars.push_back(letters[$urandom_range(6)]);
        end else begin
            add_digit(chars, $urandom_range(3), rpu_pkg::CH_M, rpu_pkg::CH_M,
                      rpu_pkg::CH_M);
            add_digit(chars, $urandom_range(9), rpu_pkg::CH_C, rpu_pkg::CH_D,
                      rpu_pkg::CH_M);
            add_digit(chars, $urandom_range(9), rpu_pkg::CH_X, rpu_pkg::CH_L,
                      rpu_pkg::CH_C);
            add_digit(chars, $urandom_range(9), rpu_pkg::CH_I, rpu_pkg::CH_V,
                      rpu_pkg::CH_X);
            if (pick < 40) begin
                pos = $urandom_range(chars.size());
                if ($urandom_range(3) != 0)
                    chars.insert(pos, letters[$urandom_range(6)]);
                else
                    chars.insert(pos, 8'($urandom_range(255)));
            end
        end
        return chars;
    endfunction

    // extremes and special cases of the grammar
    task automatic test_directed();
        send_request(rpu_pkg::CH_X, 1'b1); // empty numeral, byte on the end marker ignored
        send_text("MMMCMXCIX");            // largest value
        send_text("DCCCXXXX");             // third C and X count, fourth X rejected
        send_text("IM");                   // nothing after the units group can take M
        send_request(8'h00, 1'b0);         // zero byte rejected, later letters ignored
        send_request(rpu_pkg::CH_I, 1'b0);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
    endtask

    task automatic test_random_numerals();
        while (requests_sent < RANDOM_TARGET)
            send_numeral(random_numeral());
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_output_hold_off();
        sender_idles = 1'b0;
        repeat (2) begin
            hold_request = 1'b1;
            repeat (12) send_numeral(random_numeral());
        end
        sender_idles = 1'b1;
    endtask

    // long stretch with both sides always ready
    task automatic test_steady_stream();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        while (requests_sent < TOTAL_TARGET)
            send_numeral(random_numeral());
    endtask

    // receiver side ready, with random stalls and the long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= !(receiver_idles && $urandom_range(99) < 25);
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_numeral_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value %0d ok %0b bad_char %02h", $time,
                         out_ch.value, out_ch.ok, out_ch.bad_char);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.value !== want.value) begin
                    $display("%0t: value expected %0d, got %0d", $time, want.value,
                             out_ch.value);
                    mismatch_count++;
                end
                if (out_ch.ok !== want.ok) begin
                    $display("%0t: ok expected %0b, got %0b", $time, want.ok, out_ch.ok);
                    mismatch_count++;
                end
                if (out_ch.bad_char !== want.bad_char) begin
                    $display("%0t: bad_char expected %02h, got %02h", $time, want.bad_char,
                             out_ch.bad_char);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles in which no request moves on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, tests in turn, drain and verdict
    initial begin
        clear_parse();
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.ch     <= 8'd0;
        in_ch.is_end <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_numerals();
        test_output_hold_off();
        test_steady_stream();

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
